### hw/rtl/swp_pkg.sv
// Shared constants, types and helpers for the sliding window percentile block.
`default_nettype none

package swp_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 32;

    // Slot index into the window and counter that can hold the depth itself.
    localparam int IDX_BITS   = $clog2(WINDOW_MAX);
    localparam int COUNT_BITS = $clog2(WINDOW_MAX + 1);

    // Configuration port.
    localparam int CFG_BITS       = 7;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CALC_BITS      = (CFG_BITS > COUNT_BITS) ? CFG_BITS : COUNT_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RANK          = 2'd1;

    localparam logic [CFG_BITS-1:0] WINDOW_LENGTH_RESET = 7'd14;
    localparam logic [CFG_BITS-1:0] RANK_RESET          = 7'd1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [IDX_BITS-1:0]           idx_t;
    typedef logic [COUNT_BITS-1:0]         count_t;
    typedef logic [CFG_BITS-1:0]           cfg_t;

    // Broadcast from the controller to every cell of the sorted chain.
    typedef struct packed {
        logic    load;     // update the cell registers this cycle
        logic    steady;   // window full: evict and insert, else plain insert
        sample_t nv;       // sample being inserted
        sample_t ov;       // sample being evicted
        count_t  fill;     // number of occupied cells
    } cell_ctrl_t;

    // What a cell shows to its two neighbors.
    typedef struct packed {
        sample_t value;      // stored sample
        logic    keep;       // occupied and not above the new sample
        logic    below_old;  // strictly below the evicted sample, not the last cell
    } cell_link_t;

endpackage

`default_nettype wire

### hw/rtl/swp_in_if.sv
// Input channel: one sample with its restart flag per transaction.
`default_nettype none

interface swp_in_if;
    logic             valid;
    logic             ready;
    swp_pkg::sample_t sample;
    logic             restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

`default_nettype wire

### hw/rtl/swp_out_if.sv
// Output channel: one percentile value per transaction.
`default_nettype none

interface swp_out_if;
    logic             valid;
    logic             ready;
    swp_pkg::sample_t value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### hw/rtl/swp_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module swp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hw/rtl/swp_cell.sv
// One cell of the sorted chain: holds one sample and shifts with its neighbors.
`default_nettype none

module swp_cell (
    input  wire logic                clk,
    input  wire swp_pkg::idx_t       position,
    input  wire swp_pkg::cell_ctrl_t ctrl,
    input  wire swp_pkg::cell_link_t from_left,
    input  wire swp_pkg::cell_link_t from_right,
    output swp_pkg::cell_link_t      link
);

    swp_pkg::sample_t value_reg;
    swp_pkg::sample_t value_next;
    swp_pkg::count_t  pos_ext;
    logic             occupied;
    logic             not_last;
    logic             keep;
    logic             below_old;

    assign pos_ext   = swp_pkg::COUNT_BITS'(position);
    assign occupied  = pos_ext < ctrl.fill;
    assign not_last  = swp_pkg::COUNT_BITS'(pos_ext + 1'b1) < ctrl.fill;
    assign keep      = occupied && !($signed(ctrl.nv) < $signed(value_reg));
    assign below_old = not_last && ($signed(value_reg) < $signed(ctrl.ov));

    assign link.value     = value_reg;
    assign link.keep      = keep;
    assign link.below_old = below_old;

    // Cells in front of the insert point stay, the insert point takes the new
    // sample, and the cells between insert point and evicted entry move one
    // place toward the gap the eviction leaves.
    always_comb
    begin
        value_next = value_reg;
        if (!ctrl.steady)
        begin
            if (!keep)
            begin
                value_next = from_left.keep ? ctrl.nv : from_left.value;
            end
        end
        else
        begin
            if (!below_old && from_right.keep)
            begin
                value_next = from_right.value;
            end
            else if (!below_old && keep)
            begin
                value_next = ctrl.nv;
            end
            else if (!keep && from_left.keep && from_left.below_old)
            begin
                value_next = ctrl.nv;
            end
            else if (!from_left.keep && from_left.below_old)
            begin
                value_next = from_left.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            value_reg <= value_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sliding_window_percentile_top.sv
// Top level of the sliding window percentile filter.
//
//   Channel   Direction  Payload                      Handshake
//   samples   in         sample (32 b signed), restart valid / ready
//   results   out        value (32 b signed)          valid / ready
//   config    in         cfg_index, cfg_data (7 b)    cfg_write_en, no back-pressure
//
// A sample passes through acceptance, a read of the age ring at the oldest
// slot together with the selection of the two cells around the requested rank,
// and the update of the sorted chain and the ring. The single read port of the
// age ring makes the read a separate step. With a full window the update waits
// while a previous result still sits unread in the output register. Reset empties
// the window and needs no clearing pass; the storage itself holds no reset value.
`default_nettype none

module sliding_window_percentile_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    swp_in_if.sink                                   samples,
    swp_out_if.source                                results,
    input  wire logic                                cfg_write_en,
    input  wire logic [swp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire swp_pkg::cfg_t                       cfg_data
);

    // Controller states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    localparam int CB = swp_pkg::CALC_BITS;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    swp_pkg::cfg_t    wlen_reg;
    swp_pkg::cfg_t    rank_reg;
    swp_pkg::count_t  fill_reg;
    swp_pkg::count_t  fill_next;
    swp_pkg::idx_t    oldest_reg;
    swp_pkg::idx_t    oldest_next;
    swp_pkg::sample_t nv_reg;
    swp_pkg::sample_t lo_reg;
    swp_pkg::sample_t hi_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    swp_pkg::sample_t out_value_reg;

    // Effective window length n, retained count m = n-1 and rank r, each
    // clamped into range.
    logic [CB-1:0]    wlen_ext;
    logic [CB-1:0]    rank_ext;
    logic [CB-1:0]    n_calc;
    logic [CB-1:0]    r_calc;
    swp_pkg::count_t  win_n;
    swp_pkg::count_t  win_m;
    swp_pkg::count_t  rank_r;
    swp_pkg::idx_t    hi_idx;
    swp_pkg::idx_t    lo_idx;

    logic             accept;
    logic             restart_clear;
    logic             steady;
    logic             out_free;
    logic             produce;
    logic             chain_load;
    logic             ring_write;
    swp_pkg::idx_t    ring_waddr;
    swp_pkg::sample_t ring_rdata;
    swp_pkg::sample_t hi_pick;
    swp_pkg::sample_t result;
    swp_pkg::count_t  oldest_inc;

    swp_pkg::cell_ctrl_t ctrl;
    swp_pkg::cell_link_t links      [swp_pkg::WINDOW_MAX];
    swp_pkg::cell_link_t left_link  [swp_pkg::WINDOW_MAX];
    swp_pkg::cell_link_t right_link [swp_pkg::WINDOW_MAX];

    assign wlen_ext = CB'(wlen_reg);
    assign rank_ext = CB'(rank_reg);

    always_comb
    begin
        if (wlen_ext == '0)
        begin
            n_calc = CB'(1);
        end
        else if (wlen_ext > CB'(swp_pkg::WINDOW_MAX))
        begin
            n_calc = CB'(swp_pkg::WINDOW_MAX);
        end
        else
        begin
            n_calc = wlen_ext;
        end

        if (rank_ext == '0)
        begin
            r_calc = CB'(1);
        end
        else if (rank_ext > n_calc)
        begin
            r_calc = n_calc;
        end
        else
        begin
            r_calc = rank_ext;
        end
    end

    assign win_n  = swp_pkg::COUNT_BITS'(n_calc);
    assign win_m  = swp_pkg::COUNT_BITS'(win_n - 1'b1);
    assign rank_r = swp_pkg::COUNT_BITS'(r_calc);
    assign hi_idx = swp_pkg::IDX_BITS'(rank_r - 1'b1);
    assign lo_idx = swp_pkg::IDX_BITS'(rank_r - 2'd2);

    // Handshake and sequencing. A result only comes from a full window; in
    // that case the update waits for the output register to be free.
    assign accept        = samples.valid && samples.ready;
    assign restart_clear = samples.restart || (fill_reg > win_m);
    assign steady        = fill_reg == win_m;
    assign out_free      = !out_valid_reg || results.ready;
    assign produce       = (state_reg == ST_UPDATE) && steady && out_free;
    assign chain_load    = (state_reg == ST_UPDATE) &&
                           (!steady || (out_free && win_m != '0));
    assign ring_write    = chain_load;
    assign ring_waddr    = steady ? oldest_reg : swp_pkg::IDX_BITS'(fill_reg);
    assign oldest_inc    = swp_pkg::COUNT_BITS'(swp_pkg::COUNT_BITS'(oldest_reg) + 1'b1);

    assign samples.ready = state_reg == ST_IDLE;
    assign results.valid = out_valid_reg;
    assign results.value = out_value_reg;

    // The new sample clamped between the retained values of rank r-1 and r.
    always_comb
    begin
        hi_pick = nv_reg;
        if ((rank_r <= win_m) && !($signed(nv_reg) < $signed(hi_reg)))
        begin
            hi_pick = hi_reg;
        end
        result = hi_pick;
        if ((rank_r > swp_pkg::COUNT_BITS'(1)) && ($signed(hi_pick) < $signed(lo_reg)))
        begin
            result = lo_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        oldest_next    = oldest_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                    if (restart_clear)
                    begin
                        fill_next   = '0;
                        oldest_next = '0;
                    end
                    else if (swp_pkg::COUNT_BITS'(oldest_reg) >= win_m)
                    begin
                        oldest_next = '0;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!steady)
                begin
                    fill_next  = swp_pkg::COUNT_BITS'(fill_reg + 1'b1);
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (win_m != '0)
                    begin
                        oldest_next = (oldest_inc == win_m) ? '0 : swp_pkg::IDX_BITS'(oldest_inc);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A new window length empties the window.
        if (cfg_write_en && cfg_index == swp_pkg::REG_WINDOW_LENGTH)
        begin
            fill_next   = '0;
            oldest_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wlen_reg      <= swp_pkg::WINDOW_LENGTH_RESET;
            rank_reg      <= swp_pkg::RANK_RESET;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    swp_pkg::REG_WINDOW_LENGTH: wlen_reg <= cfg_data;
                    swp_pkg::REG_RANK:          rank_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nv_reg <= samples.sample;
        end
        if (state_reg == ST_READ)
        begin
            hi_reg <= links[hi_idx].value;
            lo_reg <= links[lo_idx].value;
        end
        if (produce)
        begin
            out_value_reg <= result;
        end
    end

    // Age ring: samples by arrival, read at the oldest slot.
    swp_ram #(
        .WIDTH (swp_pkg::SAMPLE_BITS),
        .DEPTH (swp_pkg::WINDOW_MAX)
    ) u_age_ring (
        .clk     (clk),
        .wr_en   (ring_write),
        .wr_addr (ring_waddr),
        .wr_data (nv_reg),
        .rd_addr (oldest_reg),
        .rd_data (ring_rdata)
    );

    assign ctrl.load   = chain_load;
    assign ctrl.steady = steady;
    assign ctrl.nv     = nv_reg;
    assign ctrl.ov     = ring_rdata;
    assign ctrl.fill   = fill_reg;

    // Sorted chain: cell 0 holds the smallest retained sample. The ends see a
    // fixed neighbor so that the shift rules need no special case.
    for (genvar g = 0; g < swp_pkg::WINDOW_MAX; g++)
    begin : g_cell
        if (g == 0)
        begin : g_left_end
            assign left_link[g].value     = '0;
            assign left_link[g].keep      = 1'b1;
            assign left_link[g].below_old = 1'b1;
        end
        else
        begin : g_left
            assign left_link[g] = links[g-1];
        end

        if (g == swp_pkg::WINDOW_MAX - 1)
        begin : g_right_end
            assign right_link[g].value     = '0;
            assign right_link[g].keep      = 1'b0;
            assign right_link[g].below_old = 1'b0;
        end
        else
        begin : g_right
            assign right_link[g] = links[g+1];
        end

        swp_cell u_cell (
            .clk        (clk),
            .position   (swp_pkg::IDX_BITS'(g)),
            .ctrl       (ctrl),
            .from_left  (left_link[g]),
            .from_right (right_link[g]),
            .link       (links[g])
        );
    end

endmodule

`default_nettype wire
